[hdl/cvk_pkg.sv]
// ----------------------------------------------------------------------------
// cvk_pkg: shared types and helpers for the track update unit
// Queue item layout, register indexes, reset values and saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package cvk_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CALC_W        = 82;
  localparam int Q_DEPTH       = 2;
  localparam int Q_PTR_W       = $clog2(Q_DEPTH);
  localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);

  localparam logic [31:0] ACCEL_RST = 32'd409600;
  localparam logic [31:0] MEAS_RST  = 32'd409600;
  localparam logic [31:0] GATE_RST  = 32'd1310720;
  localparam logic [7:0]  MAXM_RST  = 8'd0;

  typedef enum logic [1:0] {
    CFG_ACCEL = 2'd0,
    CFG_MEAS  = 2'd1,
    CFG_GATE  = 2'd2,
    CFG_MAXM  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic               frame_start;
    logic               has_det;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [32:0] ex;
    logic signed [32:0] ey;
    logic [7:0]         miss;
  } qitem_t;

  function automatic logic signed [47:0] sat48(input logic signed [CALC_W-1:0] x);
    logic signed [47:0] r;
    if (x[CALC_W-1:47] == '0 || x[CALC_W-1:47] == '1) begin
      r = x[47:0];
    end else begin
      r = x[CALC_W-1] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [CALC_W-1:0] x);
    logic signed [31:0] r;
    if (x[CALC_W-1:31] == '0 || x[CALC_W-1:31] == '1) begin
      r = x[31:0];
    end else begin
      r = x[CALC_W-1] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/cvk_front.sv]
// ----------------------------------------------------------------------------
// cvk_front: input side of the track update unit
// Predicts each track, forms the innovation and holds items in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cvk_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [199:0]   in_tdata,
  input  logic [1:0]     in_tuser,
  output logic           q_valid,
  output cvk_pkg::qitem_t q_item,
  input  logic           q_pop
);
  import cvk_pkg::*;

  logic signed [31:0] pos_x, pos_y, vel_x, vel_y, det_x, det_y;
  logic signed [31:0] pred_x, pred_y;
  qitem_t             new_item;
  qitem_t             q_mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               push;

  assign pos_x = in_tdata[31:0];
  assign pos_y = in_tdata[63:32];
  assign vel_x = in_tdata[95:64];
  assign vel_y = in_tdata[127:96];
  assign det_x = in_tdata[159:128];
  assign det_y = in_tdata[191:160];

  assign pred_x = sat32(CALC_W'(pos_x) + CALC_W'(vel_x));
  assign pred_y = sat32(CALC_W'(pos_y) + CALC_W'(vel_y));

  always_comb begin
    new_item.frame_start = in_tuser[0];
    new_item.has_det     = in_tuser[1];
    new_item.px          = pred_x;
    new_item.py          = pred_y;
    new_item.vx          = vel_x;
    new_item.vy          = vel_y;
    new_item.ex          = 33'(det_x) - 33'(pred_x);
    new_item.ey          = 33'(det_y) - 33'(pred_y);
    new_item.miss        = in_tdata[199:192];
  end

  assign in_tready = (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_item    = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !q_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && q_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/cvk_back.sv]
// ----------------------------------------------------------------------------
// cvk_back: sequencer and datapath of the track update unit
// Frame covariance step with divider, gate test, correction and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cvk_back #(
  parameter int FRAC_BITS = cvk_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [31:0]     cfg_data,
  input  logic            q_valid,
  input  cvk_pkg::qitem_t q_item,
  output logic            q_pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [135:0]    out_tdata,
  output logic [1:0]      out_tuser
);
  import cvk_pkg::*;

  localparam int W = CALC_W;

  typedef enum logic [15:0] {
    ST_IDLE  = 16'b0000_0000_0000_0001,
    ST_FPRED = 16'b0000_0000_0000_0010,
    ST_FSUM  = 16'b0000_0000_0000_0100,
    ST_DINIT = 16'b0000_0000_0000_1000,
    ST_DSTEP = 16'b0000_0000_0001_0000,
    ST_DEND  = 16'b0000_0000_0010_0000,
    ST_MH    = 16'b0000_0000_0100_0000,
    ST_ML    = 16'b0000_0000_1000_0000,
    ST_MS    = 16'b0000_0001_0000_0000,
    ST_MR    = 16'b0000_0010_0000_0000,
    ST_MW    = 16'b0000_0100_0000_0000,
    ST_GX    = 16'b0000_1000_0000_0000,
    ST_GY    = 16'b0001_0000_0000_0000,
    ST_GG    = 16'b0010_0000_0000_0000,
    ST_GC    = 16'b0100_0000_0000_0000,
    ST_DONE  = 16'b1000_0000_0000_0000
  } state_t;

  typedef enum logic [2:0] {
    MOP_PP_KP = 3'd0,
    MOP_CP_KP = 3'd1,
    MOP_CP_KV = 3'd2,
    MOP_EX_KP = 3'd3,
    MOP_EY_KP = 3'd4,
    MOP_EX_KV = 3'd5,
    MOP_EY_KV = 3'd6
  } mop_t;

  state_t             state_r, state_nxt;
  mop_t               op_r;
  logic [31:0]        accel_r, meas_r, gate_r;
  logic [7:0]         maxm_r;
  qitem_t             it_r;
  logic [31:0]        ax_r, ay_r;
  logic signed [47:0] cov_pos_r, cov_cross_r, cov_vel_r;
  logic signed [47:0] pp_r, cp_r, vp_r, res_r;
  logic signed [48:0] s_r;
  logic signed [31:0] gain_pos_r, gain_vel_r;
  logic signed [31:0] px_r, py_r, vx_r, vy_r;
  logic               div_sel_r, div_neg_r;
  logic [47:0]        rem_r;
  logic [30:0]        xlo_r, quo_r;
  logic [4:0]         dcnt_r;
  logic signed [65:0] prod_r, prod;
  logic signed [W-1:0] acc_r;
  logic [64:0]        sq_r;
  logic               match_r;
  logic               out_valid_r;
  logic [135:0]       out_data_r;
  logic [1:0]         out_user_r;

  logic signed [W-1:0] a_w, a_half_w, a_qtr_w;
  logic signed [47:0]  div_num, mul_a48;
  logic                div_neg, s_le0, ovf, t_ge, gate_ok, out_free;
  logic [47:0]         div_m, div_d;
  logic [W-1:0]        xw;
  logic [48:0]         div_t;
  logic [31:0]         div_gain, ovf_gain;
  logic signed [31:0]  mul_k;
  logic signed [23:0]  mul_ah;
  logic [23:0]         mul_al;
  logic signed [32:0]  mul_a, mul_b;
  logic [32:0]         ex_abs, ey_abs;
  logic [7:0]          miss_nxt;

  assign a_w      = W'({1'b0, accel_r});
  assign a_half_w = W'({1'b0, accel_r[31:1]});
  assign a_qtr_w  = W'({1'b0, accel_r[31:2]});

  assign div_num  = div_sel_r ? cp_r : pp_r;
  assign div_neg  = div_num[47];
  assign div_m    = div_neg ? (~div_num + 48'd1) : div_num;
  assign div_d    = s_r[47:0];
  assign xw       = W'(div_m) << FRAC_BITS;
  assign ovf      = xw >= (W'(div_d) << 31);
  assign s_le0    = s_r[48] || (s_r == '0);
  assign div_t    = {rem_r, xlo_r[30]};
  assign t_ge     = div_t >= {1'b0, div_d};
  assign div_gain = div_neg_r ? (~{1'b0, quo_r} + 32'd1) : {1'b0, quo_r};
  assign ovf_gain = div_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;

  always_comb begin
    case (op_r)
      MOP_PP_KP: mul_a48 = pp_r;
      MOP_CP_KP,
      MOP_CP_KV: mul_a48 = cp_r;
      MOP_EX_KP,
      MOP_EX_KV: mul_a48 = 48'(it_r.ex);
      default:   mul_a48 = 48'(it_r.ey);
    endcase
    case (op_r)
      MOP_CP_KV,
      MOP_EX_KV,
      MOP_EY_KV: mul_k = gain_vel_r;
      default:   mul_k = gain_pos_r;
    endcase
  end

  assign mul_ah = mul_a48[47:24];
  assign mul_al = mul_a48[23:0];

  always_comb begin
    case (state_r)
      ST_MH: begin
        mul_a = 33'(mul_ah);
        mul_b = 33'(mul_k);
      end
      ST_ML: begin
        mul_a = {9'b0, mul_al};
        mul_b = 33'(mul_k);
      end
      ST_GX: begin
        mul_a = {1'b0, ax_r};
        mul_b = {1'b0, ax_r};
      end
      ST_GY: begin
        mul_a = {1'b0, ay_r};
        mul_b = {1'b0, ay_r};
      end
      ST_GG: begin
        mul_a = {1'b0, gate_r};
        mul_b = {1'b0, gate_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign gate_ok = it_r.has_det && (ax_r <= gate_r) && (ay_r <= gate_r) &&
                   (sq_r <= {1'b0, prod_r[63:0]});

  assign ex_abs   = q_item.ex[32] ? (~q_item.ex + 33'd1) : q_item.ex;
  assign ey_abs   = q_item.ey[32] ? (~q_item.ey + 33'd1) : q_item.ey;
  assign q_pop    = (state_r == ST_IDLE) && q_valid;
  assign out_free = !out_valid_r || out_tready;
  assign miss_nxt = match_r ? 8'd0 : ((it_r.miss == 8'hFF) ? 8'hFF : it_r.miss + 8'd1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = q_item.frame_start ? ST_FPRED : ST_GX;
        end
      end
      ST_FPRED: state_nxt = ST_FSUM;
      ST_FSUM:  state_nxt = ST_DINIT;
      ST_DINIT: begin
        if (s_le0 || (ovf && div_sel_r)) begin
          state_nxt = ST_MH;
        end else if (!ovf) begin
          state_nxt = ST_DSTEP;
        end
      end
      ST_DSTEP: begin
        if (dcnt_r == 5'd30) begin
          state_nxt = ST_DEND;
        end
      end
      ST_DEND:  state_nxt = div_sel_r ? ST_MH : ST_DINIT;
      ST_MH:    state_nxt = ST_ML;
      ST_ML:    state_nxt = ST_MS;
      ST_MS:    state_nxt = ST_MR;
      ST_MR:    state_nxt = ST_MW;
      ST_MW: begin
        if (op_r == MOP_CP_KV) begin
          state_nxt = ST_GX;
        end else if (op_r == MOP_EY_KV) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_MH;
        end
      end
      ST_GX:    state_nxt = ST_GY;
      ST_GY:    state_nxt = ST_GG;
      ST_GG:    state_nxt = ST_GC;
      ST_GC:    state_nxt = gate_ok ? ST_MH : ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control state, registers and the shared covariance and gains.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      accel_r     <= ACCEL_RST;
      meas_r      <= MEAS_RST;
      gate_r      <= GATE_RST;
      maxm_r      <= MAXM_RST;
      cov_pos_r   <= 48'(ACCEL_RST >> 2);
      cov_cross_r <= 48'(ACCEL_RST >> 1);
      cov_vel_r   <= 48'(ACCEL_RST);
      gain_pos_r  <= '0;
      gain_vel_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ACCEL: accel_r <= cfg_data;
          CFG_MEAS:  meas_r  <= cfg_data;
          CFG_GATE:  gate_r  <= cfg_data;
          CFG_MAXM:  maxm_r  <= cfg_data[7:0];
          default:   ;
        endcase
      end
      if (state_r == ST_DINIT) begin
        if (s_le0) begin
          gain_pos_r <= '0;
          gain_vel_r <= '0;
        end else if (ovf) begin
          if (div_sel_r) begin
            gain_vel_r <= ovf_gain;
          end else begin
            gain_pos_r <= ovf_gain;
          end
        end
      end
      if (state_r == ST_DEND) begin
        if (div_sel_r) begin
          gain_vel_r <= div_gain;
        end else begin
          gain_pos_r <= div_gain;
        end
      end
      if (state_r == ST_MW) begin
        case (op_r)
          MOP_PP_KP: cov_pos_r   <= sat48(W'(pp_r) - W'(res_r));
          MOP_CP_KP: cov_cross_r <= sat48(W'(cp_r) - W'(res_r));
          MOP_CP_KV: cov_vel_r   <= sat48(W'(vp_r) - W'(res_r));
          default:   ;
        endcase
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          it_r <= q_item;
          px_r <= q_item.px;
          py_r <= q_item.py;
          vx_r <= q_item.vx;
          vy_r <= q_item.vy;
          ax_r <= ex_abs[31:0];
          ay_r <= ey_abs[31:0];
          div_sel_r <= 1'b0;
        end
      end
      ST_FPRED: begin
        pp_r <= sat48(W'(cov_pos_r) + (W'(cov_cross_r) <<< 1) + W'(cov_vel_r) + a_qtr_w);
        cp_r <= sat48(W'(cov_cross_r) + W'(cov_vel_r) + a_half_w);
        vp_r <= sat48(W'(cov_vel_r) + a_w);
      end
      ST_FSUM: begin
        s_r <= 49'(pp_r) + 49'({1'b0, meas_r});
      end
      ST_DINIT: begin
        if (s_le0 || ovf) begin
          op_r      <= MOP_PP_KP;
          div_sel_r <= 1'b1;
        end else begin
          rem_r     <= xw[78:31];
          xlo_r     <= xw[30:0];
          quo_r     <= '0;
          dcnt_r    <= '0;
          div_neg_r <= div_neg;
        end
      end
      ST_DSTEP: begin
        if (t_ge) begin
          rem_r <= 48'(div_t - {1'b0, div_d});
        end else begin
          rem_r <= div_t[47:0];
        end
        quo_r  <= {quo_r[29:0], t_ge};
        xlo_r  <= {xlo_r[29:0], 1'b0};
        dcnt_r <= dcnt_r + 5'd1;
      end
      ST_DEND: begin
        div_sel_r <= 1'b1;
        op_r      <= MOP_PP_KP;
      end
      ST_MH: begin
        prod_r <= prod;
      end
      ST_ML: begin
        acc_r  <= W'(prod_r) <<< 24;
        prod_r <= prod;
      end
      ST_MS: begin
        acc_r <= acc_r + W'(prod_r);
      end
      ST_MR: begin
        res_r <= sat48(acc_r >>> FRAC_BITS);
      end
      ST_MW: begin
        case (op_r)
          MOP_PP_KP: op_r <= MOP_CP_KP;
          MOP_CP_KP: op_r <= MOP_CP_KV;
          MOP_EX_KP: begin
            px_r <= sat32(W'(px_r) + W'(res_r));
            op_r <= MOP_EY_KP;
          end
          MOP_EY_KP: begin
            py_r <= sat32(W'(py_r) + W'(res_r));
            op_r <= MOP_EX_KV;
          end
          MOP_EX_KV: begin
            vx_r <= sat32(W'(vx_r) + W'(res_r));
            op_r <= MOP_EY_KV;
          end
          MOP_EY_KV: vy_r <= sat32(W'(vy_r) + W'(res_r));
          default:   ;
        endcase
      end
      ST_GX: begin
        prod_r <= prod;
      end
      ST_GY: begin
        sq_r   <= {1'b0, prod_r[63:0]};
        prod_r <= prod;
      end
      ST_GG: begin
        sq_r   <= sq_r + {1'b0, prod_r[63:0]};
        prod_r <= prod;
      end
      ST_GC: begin
        match_r <= gate_ok;
        op_r    <= MOP_EX_KP;
      end
      ST_DONE: begin
        if (out_free) begin
          out_data_r <= {miss_nxt, vy_r, vx_r, py_r, px_r};
          out_user_r <= {(miss_nxt > maxm_r), match_r};
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

[hdl/cv_kalman_tracker_update_unit.sv]
// ----------------------------------------------------------------------------
// cv_kalman_tracker_update_unit: constant-velocity Kalman track update
// Shared covariance frame step, gated correction and miss counting per track.
//
// Channel  Direction  Content
// in_      slave      tdata: pos_x, pos_y, vel_x, vel_y, det_x, det_y, miss_count
//                     tuser: frame_start, has_detection
// out_     master     tdata: new_pos_x, new_pos_y, new_vel_x, new_vel_y,
//                            new_miss_count; tuser: matched, drop_track
// cfg_     write      accel_variance, meas_variance, gate_distance, max_misses
//
// An item without a match goes from the gate test to the result; with one, four
// products follow, each through MH, ML, MS, MR and MW on the single 33x33
// multiplier. A frame_start item adds the covariance step, mostly two 31-step
// restoring divisions, one bit a cycle. Reset is synchronous. A two-item queue
// decouples input from sequencer; the output register holds a result under stall.
// ----------------------------------------------------------------------------
`default_nettype none

module cv_kalman_tracker_update_unit #(
  parameter int FRAC_BITS = cvk_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [199:0] in_tdata,   // pos_x, pos_y, vel_x, vel_y, det_x, det_y, miss_count
  input  logic [1:0]   in_tuser,   // frame_start, has_detection
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // new_pos_x, new_pos_y, new_vel_x, new_vel_y, new_miss_count
  output logic [1:0]   out_tuser,  // matched, drop_track
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import cvk_pkg::*;

  logic   q_valid;
  logic   q_pop;
  qitem_t q_item;

  cvk_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  cvk_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

[hdl/cvk_checker.sv]
// ----------------------------------------------------------------------------
// cvk_checker: port-level checks for the track update unit
// Output handshake and miss count consistency, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cvk_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [135:0] out_tdata,
  input logic [1:0]   out_tuser
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result item withdrawn under stall");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result item changed under stall");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_match_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[135:128] == 8'd0)
    else $error("matched item with nonzero miss count");

  a_miss_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[135:128] != 8'd0)
    else $error("unmatched item with zero miss count");

endmodule

bind cv_kalman_tracker_update_unit cvk_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
